### rtl/core/sat_pkg.sv
`default_nettype none
package sat_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_SELECT = 2'd1;
   localparam logic [1:0] OP_EXACT  = 2'd2;
   localparam logic [1:0] OP_PREFIX = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_UNSPEC   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   localparam logic [2:0] KIND_GLOBAL  = 3'd3;
   localparam logic [2:0] KIND_SOLNODE = 3'd5;

   localparam logic [63:0] SOL_HIGH = 64'hff02_0000_0000_0000;

   // token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [1:0]  op;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        hit;
      logic        sol_hit;
      logic [3:0]  idx;
      logic [63:0] fh;
      logic [63:0] fl;
      logic [2:0]  fs;
      logic [2:0]  ft;
      logic [7:0]  pfx;
   } sat_token_type;

   typedef struct packed {
      logic        we;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [2:0]  state;
      logic [2:0]  kind;
   } sat_wr_type;

   function automatic logic [63:0] sol_low(input logic [63:0] lo);
      sol_low = {32'h0000_0001, 8'hff, lo[23:0]};
   endfunction

   function automatic logic is_ll(input logic [63:0] hi);
      is_ll = (hi[63:48] == 16'hfe80);
   endfunction

   function automatic logic is_mc(input logic [63:0] hi);
      is_mc = (hi[63:56] == 8'hff);
   endfunction

   function automatic logic is_ula(input logic [63:0] hi);
      is_ula = (hi[63:56] == 8'hfc) || (hi[63:56] == 8'hfd);
   endfunction

   // leading zeros of a 128-bit word, 0..128, seven halving steps
   function automatic logic [7:0] clz128(input logic [127:0] v);
      logic [127:0] w;
      logic [7:0]   n;
      w = v;
      n = 8'd0;
      if (w[127:64] == '0) begin n = n + 8'd64; w = w << 64; end
      if (w[127:96] == '0) begin n = n + 8'd32; w = w << 32; end
      if (w[127:112] == '0) begin n = n + 8'd16; w = w << 16; end
      if (w[127:120] == '0) begin n = n + 8'd8; w = w << 8; end
      if (w[127:124] == '0) begin n = n + 8'd4; w = w << 4; end
      if (w[127:126] == '0) begin n = n + 8'd2; w = w << 2; end
      if (!w[127]) begin n = n + 8'd1; w = w << 1; end
      if (!w[127]) n = n + 8'd1;
      clz128 = n;
   endfunction

endpackage
`default_nettype wire

### rtl/core/sat_req_if.sv
`default_nettype none
interface sat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [2:0]  entry_state;
   logic [2:0]  entry_type;
   modport source (output valid, opcode, addr_high, addr_low, entry_state, entry_type,
                   input ready);
   modport sink (input valid, opcode, addr_high, addr_low, entry_state, entry_type,
                 output ready);
endinterface
`default_nettype wire

### rtl/core/sat_rsp_if.sv
`default_nettype none
interface sat_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] found_high;
   logic [63:0] found_low;
   logic [3:0]  found_index;
   logic [2:0]  found_state;
   logic [2:0]  found_type;
   logic [7:0]  prefix_bits;
   logic [4:0]  entries_used;
   modport source (output valid, status, found_high, found_low, found_index, found_state,
                   found_type, prefix_bits, entries_used, input ready);
   modport sink (input valid, status, found_high, found_low, found_index, found_state,
                 found_type, prefix_bits, entries_used, output ready);
endinterface
`default_nettype wire

### rtl/core/sat_cell.sv
`default_nettype none
module sat_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 4,
   parameter int FW    = 5
) (
   input  wire                       clock,
   input  wire                       reset,
   input  sat_pkg::sat_token_type    tok_in,
   output sat_pkg::sat_token_type    tok_out,
   input  sat_pkg::sat_wr_type       wr,
   input  wire [IW-1:0]              wr_index,
   input  wire [FW-1:0]              fill,
   input  wire [2:0]                 pref
);
   logic [63:0] eh_ff;
   logic [63:0] el_ff;
   logic [2:0]  es_ff;
   logic [2:0]  ek_ff;
   sat_pkg::sat_token_type tok_ff;
   sat_pkg::sat_token_type tok_in_c;

   logic       filled;
   logic       exact;
   logic       take;
   logic       cand;
   logic [7:0] cp;

   assign filled = FW'(INDEX) < fill;
   assign exact  = (eh_ff == tok_in.hi) && (el_ff == tok_in.lo);
   assign cp     = sat_pkg::clz128({tok_in.hi ^ eh_ff, tok_in.lo ^ el_ff});

   always_comb begin
      tok_in_c = tok_in;
      take     = 1'b0;
      cand     = 1'b0;
      case (tok_in.op)
         sat_pkg::OP_ADD: begin
            take = filled && exact && !tok_in.hit;
            if (filled && eh_ff == sat_pkg::SOL_HIGH && el_ff == sat_pkg::sol_low(tok_in.lo))
               tok_in_c.sol_hit = 1'b1;
         end
         sat_pkg::OP_EXACT:  take = filled && exact && !tok_in.hit;
         sat_pkg::OP_PREFIX: take = filled && (eh_ff == tok_in.hi) && !tok_in.hit;
         default: begin
            if (sat_pkg::is_ll(tok_in.hi) || sat_pkg::is_mc(tok_in.hi))
               cand = sat_pkg::is_ll(eh_ff) && !sat_pkg::is_mc(eh_ff);
            else
               cand = !sat_pkg::is_ll(eh_ff) && !sat_pkg::is_mc(eh_ff) &&
                      !sat_pkg::is_ula(eh_ff) && (cp >= tok_in.pfx);
            take = filled && (es_ff == pref) && cand;
         end
      endcase
      if (take) begin
         tok_in_c.hit = 1'b1;
         tok_in_c.idx = 4'(INDEX);
         tok_in_c.fh  = eh_ff;
         tok_in_c.fl  = el_ff;
         tok_in_c.fs  = es_ff;
         tok_in_c.ft  = ek_ff;
         if (tok_in.op == sat_pkg::OP_SELECT) tok_in_c.pfx = cp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tok_ff <= '0;
      else tok_ff <= tok_in_c;
      if (wr.we && wr_index == IW'(INDEX)) begin
         eh_ff <= wr.hi;
         el_ff <= wr.lo;
         es_ff <= wr.state;
         ek_ff <= wr.kind;
      end
   end

   assign tok_out = tok_ff;
endmodule
`default_nettype wire

### rtl/core/ipv6_source_address_table.sv
`default_nettype none
// IPv6 interface address table with source address selection.
// req: one beat per operation (add, select, exact lookup, upper-64 lookup).
// rsp: exactly one beat per request, in order, carrying status and the entry.
// csr: csr_write_enable/csr_write_data set the preferred state code (reset 0);
//      write only while no operation is in flight.
// Each entry lives in a cell of a chain; a query token walks the chain one
// cell per cycle, so the scan ends when the token leaves the last cell,
// where an added entry is stored. The result registers are loaded then; an
// add that also needs the solicited-node entry stores it from the SOL state
// first. From the finish state the result goes into the response register.
// One operation at a time.
// The next request is taken in the cycle after the response register is
// loaded, even while that beat still waits for rsp.ready.
// If the receiver stalls, a finished result waits in the finish state until
// the response register frees up.
// Reset (synchronous) empties the table (fill count to zero), clears the
// preferred code and drops any operation in flight.
module ipv6_source_address_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire       clock,
   input  wire       reset,
   sat_req_if.sink   req,
   sat_rsp_if.source rsp,
   input  wire       csr_write_enable,
   input  wire [2:0] csr_write_data
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SOL, S_DONE} state_type;

   state_type    state_ff;
   logic [FW-1:0] fill_ff;
   logic [2:0]   pref_ff;
   logic [2:0]   rst_ff;   // stored state of the add
   logic [2:0]   rkd_ff;   // stored type of the add
   logic [63:0]  rhi_ff;
   logic [63:0]  rlo_ff;

   logic [2:0]   res_status_ff;
   logic [63:0]  res_high_ff;
   logic [63:0]  res_low_ff;
   logic [3:0]   res_index_ff;
   logic [2:0]   res_state_ff;
   logic [2:0]   res_type_ff;
   logic [7:0]   res_pfx_ff;

   logic         rsp_valid_ff;
   logic [2:0]   rsp_status_ff;
   logic [63:0]  rsp_high_ff;
   logic [63:0]  rsp_low_ff;
   logic [3:0]   rsp_index_ff;
   logic [2:0]   rsp_state_ff;
   logic [2:0]   rsp_type_ff;
   logic [7:0]   rsp_pfx_ff;
   logic [4:0]   rsp_used_ff;

   sat_pkg::sat_token_type tok [TABLE_DEPTH+1];
   sat_pkg::sat_token_type last;
   sat_pkg::sat_wr_type    wr;
   logic [IW-1:0]          wr_index;
   logic                   accept;
   logic                   unspec;
   logic                   is_full;
   logic                   add_ok;
   logic                   sol_need;
   logic [63:0]            sl;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   always_comb begin
      tok[0]       = '0;
      tok[0].valid = accept;
      tok[0].op    = req.opcode;
      tok[0].hi    = req.addr_high;
      tok[0].lo    = req.addr_low;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      sat_cell #(.INDEX(g), .IW(IW), .FW(FW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok[g]),
         .tok_out  (tok[g+1]),
         .wr       (wr),
         .wr_index (wr_index),
         .fill     (fill_ff),
         .pref     (pref_ff)
      );
   end

   assign last    = tok[TABLE_DEPTH];
   assign sl      = sat_pkg::sol_low(rlo_ff);
   assign unspec  = (last.hi == '0) && (last.lo == '0);
   assign is_full = fill_ff >= FW'(TABLE_DEPTH);
   // add that stores a new entry
   assign add_ok  = (state_ff == S_SCAN) && last.valid && (last.op == sat_pkg::OP_ADD) &&
                    !unspec && !last.hit && !is_full;
   // solicited-node entry also needed; the new entry itself counts as present
   assign sol_need = (rkd_ff <= sat_pkg::KIND_GLOBAL) && !last.sol_hit &&
                     !(last.hi == sat_pkg::SOL_HIGH && last.lo == sl) &&
                     ((fill_ff + 1'b1) < FW'(TABLE_DEPTH));

   always_comb begin
      wr       = '0;
      wr_index = fill_ff[IW-1:0];
      if (add_ok) begin
         wr.we    = 1'b1;
         wr.hi    = last.hi;
         wr.lo    = last.lo;
         wr.state = rst_ff;
         wr.kind  = rkd_ff;
      end else if (state_ff == S_SOL) begin
         wr.we    = 1'b1;
         wr.hi    = sat_pkg::SOL_HIGH;
         wr.lo    = sl;
         wr.state = rst_ff;
         wr.kind  = sat_pkg::KIND_SOLNODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pref_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) pref_ff <= csr_write_data;
         // in the finish state the load below decides the valid bit
         if (rsp_valid_ff && rsp.ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rst_ff   <= req.entry_state;
                  rkd_ff   <= req.entry_type;
                  rlo_ff   <= req.addr_low;
                  rhi_ff   <= req.addr_high;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (last.valid) begin
                  res_high_ff  <= last.fh;
                  res_low_ff   <= last.fl;
                  res_index_ff <= last.idx;
                  res_state_ff <= last.fs;
                  res_type_ff  <= last.ft;
                  res_pfx_ff   <= last.pfx;
                  state_ff     <= S_DONE;
                  if (last.op == sat_pkg::OP_ADD) begin
                     res_pfx_ff <= '0;
                     if (unspec) begin
                        res_status_ff <= sat_pkg::ST_UNSPEC;
                     end else if (last.hit) begin
                        res_status_ff <= sat_pkg::ST_DUP;
                     end else if (is_full) begin
                        res_status_ff <= sat_pkg::ST_FULL;
                     end else begin
                        res_status_ff <= sat_pkg::ST_OK;
                        res_high_ff   <= rhi_ff;
                        res_low_ff    <= rlo_ff;
                        res_index_ff  <= 4'(fill_ff);
                        res_state_ff  <= rst_ff;
                        res_type_ff   <= rkd_ff;
                        fill_ff       <= fill_ff + 1'b1;
                        if (sol_need) state_ff <= S_SOL;
                     end
                  end else begin
                     res_status_ff <= last.hit ? sat_pkg::ST_OK : sat_pkg::ST_NOTFOUND;
                  end
               end
            end
            S_SOL: begin
               fill_ff  <= fill_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_high_ff   <= res_high_ff;
                  rsp_low_ff    <= res_low_ff;
                  rsp_index_ff  <= res_index_ff;
                  rsp_state_ff  <= res_state_ff;
                  rsp_type_ff   <= res_type_ff;
                  rsp_pfx_ff    <= res_pfx_ff;
                  rsp_used_ff   <= 5'(fill_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.found_high   = rsp_high_ff;
   assign rsp.found_low    = rsp_low_ff;
   assign rsp.found_index  = rsp_index_ff;
   assign rsp.found_state  = rsp_state_ff;
   assign rsp.found_type   = rsp_type_ff;
   assign rsp.prefix_bits  = rsp_pfx_ff;
   assign rsp.entries_used = rsp_used_ff;
endmodule
`default_nettype wire

### rtl/core/sat_checker.sv
`default_nettype none
module sat_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_status,
   input wire [63:0] rsp_found_high,
   input wire [63:0] rsp_found_low,
   input wire [7:0]  rsp_prefix_bits,
   input wire [4:0]  rsp_entries_used
);
   logic [4:0] used_ff;

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (rsp_valid && rsp_ready) used_ff <= rsp_entries_used;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sat_pkg::ST_NOTFOUND |->
      rsp_found_high == '0 && rsp_found_low == '0 && rsp_prefix_bits == '0)
      else $error("miss carries entry data");

   a_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_entries_used >= used_ff)
      else $error("fill count went down");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries_used <= 5'(TABLE_DEPTH) && rsp_status <= sat_pkg::ST_NOTFOUND)
      else $error("fill count or status out of range");
endmodule

bind ipv6_source_address_table sat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sat_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_found_high   (rsp.found_high),
   .rsp_found_low    (rsp.found_low),
   .rsp_prefix_bits  (rsp.prefix_bits),
   .rsp_entries_used (rsp.entries_used)
);
`default_nettype wire
